// File: sv/smsd_pkg.sv
// ----------------------------------------------------------------------------
// smsd_pkg
// shared widths and the result beat layout of the key matrix scanner
// ----------------------------------------------------------------------------
`default_nettype none

package smsd_pkg;

   localparam int KeyWidth    = 8;   // column bits per row in the key store
   localparam int AdcWidth    = 8;
   localparam int SumWidth    = 11;  // running analog sum, wraps
   localparam int AvgWidth    = 8;
   localparam int DriveWidth  = 2;
   localparam int CfgWidth    = 3;   // one active-low bit per reported row
   localparam int OutRows     = 3;   // rows reported on the result beat
   localparam int RecipShift  = 16;  // fraction bits of the averaging reciprocal

   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 40;

   // result beat payload, drive_row in the lowest bits
   typedef struct packed {
      logic [AvgWidth-1:0]   analog_value;
      logic [KeyWidth-1:0]   keys_row2;
      logic [KeyWidth-1:0]   keys_row1;
      logic [KeyWidth-1:0]   keys_row0;
      logic [DriveWidth-1:0] drive_row;
   } result_type;

endpackage : smsd_pkg

`default_nettype wire

// File: sv/smsd_avg_div.sv
// ----------------------------------------------------------------------------
// smsd_avg_div
// divides the analog sum by the ticks of one full scan (2 * ROWS)
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_avg_div #(
   parameter int ROWS = 3
) (
   input  wire logic [smsd_pkg::SumWidth-1:0] sum,
   output      logic [smsd_pkg::AvgWidth-1:0] average
);

   localparam int HalfWidth = smsd_pkg::SumWidth - 1;
   // ceil(2^16 / ROWS); exact floor for any 10-bit dividend and ROWS up to 8
   localparam int RecipWidth = smsd_pkg::RecipShift + 1;
   localparam logic [RecipWidth-1:0] Recip =
      RecipWidth'(((1 << smsd_pkg::RecipShift) + ROWS - 1) / ROWS);
   localparam int ProdWidth = HalfWidth + RecipWidth;

   logic [HalfWidth-1:0] half;
   logic [ProdWidth-1:0] product;

   // divide by two is a shift, divide by rows is a reciprocal multiply
   assign half    = sum[smsd_pkg::SumWidth-1:1];
   assign product = ProdWidth'(half) * ProdWidth'(Recip);
   assign average = product[smsd_pkg::RecipShift +: smsd_pkg::AvgWidth];

endmodule : smsd_avg_div

`default_nettype wire

// File: sv/switch_matrix_scan_debounce.sv
// ----------------------------------------------------------------------------
// switch_matrix_scan_debounce
// key matrix scanner with two-sample agreement debounce and analog averaging
// ----------------------------------------------------------------------------
// each req beat is one scan tick: the raw column read of the row now driven
// and one adc sample. each rsp beat gives the row to drive next, the
// debounced keys of rows 0..2, the averaged analog value and, in tuser, a
// flag that the average was renewed on this tick.
// every row is read on two successive ticks; on the second one a key bit
// takes the new read only where both reads agree, then the row advances.
// after every 2*ROWS ticks the adc sum divided by 2*ROWS becomes the new
// analog value and the sum starts over.
// csr port: one write sets the active-low row mask (bit r inverts row r);
// write it only while no tick is in flight. csr_ready is always high.
// path: a req beat is taken into the input register and then, on a step, its
// result goes into the result register, from which its rsp beat is offered.
// throughput: one beat per cycle while rsp is not stalled; the whole tick is one pass of logic
// between the input register and the result register.
// a stalled rsp holds its beat; one more req beat is taken into the input
// register, then req_tready drops until rsp moves again.
// reset clears the row counter, the key store, the sum and the average, and
// loads the active-low mask with rows 0 and 1 set.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_matrix_scan_debounce #(
   parameter int ROWS    = 3,
   parameter int COLUMNS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request ticks
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [smsd_pkg::ReqDataWidth-1:0]   req_tdata,   // column_bits, adc_sample
   // results
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [smsd_pkg::RspDataWidth-1:0]   rsp_tdata,   // drive_row, keys_row0,
                                                                 // keys_row1, keys_row2,
                                                                 // analog_value, zero pad
   output      logic                                rsp_tuser,   // analog_fresh
   // active-low row mask
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [smsd_pkg::CfgWidth-1:0]       csr_data
);

   localparam int RowWidth = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int KW       = smsd_pkg::KeyWidth;
   localparam logic [KW-1:0] ColMask =
      (COLUMNS >= KW) ? {KW{1'b1}} : KW'((1 << COLUMNS) - 1);
   localparam logic [RowWidth-1:0] LastRow = RowWidth'(ROWS - 1);
   localparam logic [smsd_pkg::CfgWidth-1:0] MaskReset = smsd_pkg::CfgWidth'(3);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [KW-1:0]        in_cols_ff;
   logic [smsd_pkg::AdcWidth-1:0] in_adc_ff;

   // scan state
   logic [smsd_pkg::CfgWidth-1:0] low_mask_ff;
   logic [RowWidth-1:0]  row_ff, row_in;
   logic                 second_ff;
   logic [KW-1:0]        prev_ff;
   logic [KW-1:0]        keys_ff [ROWS];
   logic [smsd_pkg::SumWidth-1:0] sum_ff, sum_in;
   logic [smsd_pkg::AvgWidth-1:0] avg_ff, avg_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   smsd_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 rsp_fresh_ff;

   logic                 req_fire;
   logic                 step;
   logic                 invert;
   logic [KW-1:0]        cols;
   logic [KW-1:0]        agree;
   logic [KW-1:0]        key_new;
   logic                 last_row;
   logic                 fresh;
   logic [smsd_pkg::SumWidth-1:0] sum_add;
   logic [smsd_pkg::AvgWidth-1:0] quotient;
   logic [smsd_pkg::OutRows-1:0][KW-1:0] keys_vis;

   // handshakes
   assign req_fire   = req_tvalid && req_tready;
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   always_comb begin
      priority if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // row polarity, only the reported rows have a mask bit
   assign invert = (int'(row_ff) < smsd_pkg::OutRows) && low_mask_ff[2'(row_ff)];
   assign cols   = in_cols_ff ^ {KW{invert}};

   // agreement debounce, columns past COLUMNS stay zero
   assign agree   = ~(cols ^ prev_ff) & ColMask;
   assign key_new = (keys_ff[row_ff] & ~agree) | (cols & agree);

   assign last_row = (row_ff == LastRow);
   assign fresh    = second_ff && last_row;

   always_comb begin
      priority if (second_ff && last_row) begin
         row_in = '0;
      end else if (second_ff) begin
         row_in = RowWidth'(row_ff + 1'b1);
      end else begin
         row_in = row_ff;
      end
   end

   // analog sum and average
   assign sum_add = smsd_pkg::SumWidth'(sum_ff + smsd_pkg::SumWidth'(in_adc_ff));

   smsd_avg_div #(
      .ROWS    (ROWS)
   ) u_avg_div (
      .sum     (sum_add),
      .average (quotient)
   );

   assign sum_in = fresh ? '0 : sum_add;
   assign avg_in = fresh ? quotient : avg_ff;

   // keys as they stand after this tick
   for (genvar g = 0; g < smsd_pkg::OutRows; g++) begin : g_vis
      if (g < ROWS) begin : g_row
         assign keys_vis[g] = (second_ff && row_ff == RowWidth'(g)) ? key_new : keys_ff[g];
      end else begin : g_absent
         assign keys_vis[g] = '0;
      end
   end

   always_comb begin
      rsp_data_in.drive_row    = smsd_pkg::DriveWidth'(row_in);
      rsp_data_in.keys_row0    = keys_vis[0];
      rsp_data_in.keys_row1    = keys_vis[1];
      rsp_data_in.keys_row2    = keys_vis[2];
      rsp_data_in.analog_value = avg_in;
   end

   always_comb begin
      priority if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low_mask_ff  <= MaskReset;
         row_ff       <= '0;
         second_ff    <= 1'b0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            low_mask_ff <= csr_data;
         end
         if (step) begin
            row_ff    <= row_in;
            second_ff <= !second_ff;
            prev_ff   <= cols;
            sum_ff    <= sum_in;
            avg_ff    <= avg_in;
         end
      end
   end

   // key store, one byte per row
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            keys_ff[r] <= '0;
         end
      end else if (step && second_ff) begin
         keys_ff[row_ff] <= key_new;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cols_ff <= req_tdata[KW-1:0];
         in_adc_ff  <= req_tdata[KW +: smsd_pkg::AdcWidth];
      end
      if (step) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_fresh_ff <= fresh;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = smsd_pkg::RspDataWidth'(rsp_data_ff);
   assign rsp_tuser  = rsp_fresh_ff;

   // row counter stays inside the matrix
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= LastRow)
      else $error("row counter beyond last row");

   // a fresh average only comes with the wrap back to row 0
   a_fresh_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[smsd_pkg::DriveWidth-1:0] == '0)
      else $error("fresh average without row wrap");

   // the first read of a row never advances the row
   a_first_holds: assert property (@(posedge clock) disable iff (reset)
      step && !second_ff |=> $stable(row_ff))
      else $error("row advanced on first read");

   // the sum restarts after each average
   a_sum_clear: assert property (@(posedge clock) disable iff (reset)
      step && fresh |=> sum_ff == '0)
      else $error("analog sum not cleared");

endmodule : switch_matrix_scan_debounce

`default_nettype wire
